// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the particle pool rtl
// no dependencies; aclk and aresetn must exist where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLY(label, pre, post)
`endif
`endif

// ===== rtl/core/ppool_pkg.sv =====
// particle pool package: entry type, codes, fixed point helpers, sine table builder
// no dependencies
package ppool_pkg;

    localparam int POOL_SIZE_DEF = 64;
    localparam int CNT_W = 7;
    localparam int SLOT_W = 6;
    localparam int LIFE_W = 21;
    localparam int LIFETIME_W = 20;
    localparam int GRAV_W = 21;
    localparam int FT_W = 16;
    localparam int SIN_N = 91;
    localparam int CFG_W = 21;

    localparam logic [1:0] CFG_ANIM = 2'd0;
    localparam logic [1:0] CFG_LIFETIME = 2'd1;
    localparam logic [1:0] CFG_GRAVITY = 2'd2;

    localparam logic [1:0] KIND_SPAWN = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_OFF = 2'd2;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [LIFE_W-1:0]  life;
        logic [31:0]        rgba;
    } particle_t;

    typedef struct packed {
        logic       neg;
        logic [6:0] q;
    } fold_t;

    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607) return 24'sh7fffff;
        if (v < -27'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    // round to nearest, ties away from zero, shift by 16
    function automatic logic signed [25:0] round16(input logic signed [40:0] p);
        logic [40:0] mag;
        logic [40:0] r;
        mag = p[40] ? 41'(-p) : p;
        r = (mag + 41'd32768) >> 16;
        return p[40] ? -$signed(26'(r)) : $signed(26'(r));
    endfunction

    function automatic logic [8:0] mod360(input logic [9:0] v);
        return (v >= 10'd360) ? 9'(v - 10'd360) : v[8:0];
    endfunction

    function automatic fold_t fold_angle(input logic [8:0] a);
        fold_t f;
        if (a <= 9'd90) begin
            f.neg = 1'b0; f.q = a[6:0];
        end else if (a <= 9'd180) begin
            f.neg = 1'b0; f.q = 7'(9'd180 - a);
        end else if (a <= 9'd270) begin
            f.neg = 1'b1; f.q = 7'(a - 9'd180);
        end else begin
            f.neg = 1'b1; f.q = 7'(9'd360 - a);
        end
        return f;
    endfunction

    // shift and subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter sine magnitudes in q15 from a taylor series in q30
    function automatic logic [SIN_N*16-1:0] build_sin_rom();
        logic [SIN_N*16-1:0] rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        rom = '0;
        for (int d = 0; d < SIN_N; d++) begin
            x = longint'(d) * 64'd18740330;
            x2 = (x * x) >> 30;
            t = x;
            s = x;
            for (int k = 1; k <= 6; k++) begin
                t = udiv64((t * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
                if ((k & 1) != 0) s = s - t;
                else s = s + t;
            end
            s = (s + 64'd16384) >> 15;
            if (s > 64'd32768) s = 64'd32768;
            rom[d*16 +: 16] = s[15:0];
        end
        return rom;
    endfunction

endpackage

// ===== rtl/core/ppool_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module ppool_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/ppool_div.sv =====
// restoring divider for the alpha fade, one quotient bit per cycle, 8 bit quotient
// uses ppool_pkg for widths
module ppool_div
    import ppool_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [27:0]           dividend,
    input  logic [LIFETIME_W-1:0] divisor,
    output logic                  done,
    output logic [7:0]            quot
);
    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  step_reg;
    logic [27:0] rem_reg;
    logic [7:0]  q_reg;
    logic [27:0] dshift;

    assign dshift = 28'(divisor) << step_reg;
    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd7;
                rem_reg <= dividend;
                q_reg <= '0;
            end else if (busy_reg) begin
                if (rem_reg >= dshift) begin
                    rem_reg <= rem_reg - dshift;
                    q_reg[step_reg] <= 1'b1;
                end
                step_reg <= step_reg - 3'd1;
                if (step_reg == 3'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/core/particle_pool_physics_step_core.sv =====
// particle pool top level: sequencer, particle ram, alpha divider, config registers
// uses ppool_pkg, ppool_ram, ppool_div and assert_macros.svh
//
// One input item at a time. A spawn passes through a multiply state and a write state,
// waiting in the write state while the result port is busy. A tick walks the pool twice
// through the single particle ram port: an update pass (read, multiply, round, alpha
// divide, write back) per surviving particle, with the last particle moved into the
// slot of each expired one, then a report pass over the survivors.
`include "assert_macros.svh"
module particle_pool_physics_step_core
    import ppool_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // spawn_x, spawn_y, rgba, angle_deg, speed_extra, tick_dt
    input  logic         s_tuser,  // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // spawn_status, slot, out_x, out_y, out_rgba, live_count
    output logic [1:0]   m_tuser,  // kind
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);
    localparam int AW = POOL_SIZE > 1 ? $clog2(POOL_SIZE) : 1;
    localparam int PW = $bits(particle_t);
    localparam logic [SIN_N*16-1:0] SIN_ROM = build_sin_rom();

    typedef enum logic [3:0] {
        ST_IDLE, ST_SP_MUL, ST_SP_WR, ST_T_LOOP, ST_T_EVAL, ST_T_MOVE,
        ST_T_UPD, ST_T_DIV, ST_E_LOOP, ST_E_OUT
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] cnt_reg, idx_reg;
    logic anim_reg;
    logic [LIFETIME_W-1:0] lifetime_reg;
    logic signed [GRAV_W-1:0] grav_reg;

    logic signed [23:0] in_x_reg, in_y_reg;
    logic [31:0] in_rgba_reg;
    logic [8:0] ang_reg;
    logic [7:0] spd_reg;
    logic [FT_W-1:0] ft_reg;

    logic [23:0] sinp_reg, cosp_reg;
    logic sin_neg_reg, cos_neg_reg;

    particle_t cur_reg;
    logic signed [40:0] prodx_reg, prody_reg, prodg_reg;
    logic [LIFE_W-1:0] life_new_reg;
    logic signed [23:0] px_reg, py_reg, vy_reg;
    logic sat_alpha_reg;

    logic m_valid_reg, m_last_reg;
    logic [1:0] m_kind_reg;
    logic [95:0] m_data_reg;

    logic out_free;
    logic m_load;
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    particle_t ram_wdata, ram_rdata;

    logic div_start, div_done;
    logic [7:0] div_quot;
    logic [7:0] alpha;

    logic [8:0] a_mod;
    fold_t f_sin, f_cos;
    logic [16:0] r_sin, r_cos;
    logic signed [24:0] v_sin, v_cos;
    logic signed [16:0] ft_s;
    logic [CNT_W-1:0] cnt_dec;
    logic expired;

    assign out_free = !m_valid_reg || m_tready;
    assign m_load = ((state_reg == ST_SP_WR) && out_free) ||
                    ((state_reg == ST_E_LOOP) && out_free && (cnt_reg == '0)) ||
                    (state_reg == ST_E_OUT);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;

    assign a_mod = mod360({1'b0, ang_reg});
    assign f_sin = fold_angle(a_mod);
    assign f_cos = fold_angle(mod360(10'(a_mod) + 10'd90));
    assign r_sin = 17'((25'(sinp_reg) + 25'd64) >> 7);
    assign r_cos = 17'((25'(cosp_reg) + 25'd64) >> 7);
    assign v_sin = sin_neg_reg ? -$signed(25'(r_sin)) : $signed(25'(r_sin));
    assign v_cos = cos_neg_reg ? -$signed(25'(r_cos)) : $signed(25'(r_cos));
    assign ft_s = $signed({1'b0, ft_reg});
    assign cnt_dec = cnt_reg - 7'd1;
    assign expired = ram_rdata.life <= LIFE_W'(ft_reg);
    assign alpha = sat_alpha_reg ? 8'd255 : div_quot;
    assign div_start = (state_reg == ST_T_UPD);

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[AW-1:0];
        case (state_reg)
            ST_SP_WR: begin
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata.px = in_x_reg;
                ram_wdata.py = in_y_reg;
                ram_wdata.vx = sat24(27'(v_cos));
                ram_wdata.vy = sat24(27'(v_sin) - 27'sd25600);
                ram_wdata.life = LIFE_W'(lifetime_reg);
                ram_wdata.rgba = in_rgba_reg;
                ram_we = out_free && anim_reg && (cnt_reg < CNT_W'(POOL_SIZE));
            end
            ST_T_EVAL: begin
                ram_raddr = cnt_dec[AW-1:0];
            end
            ST_T_MOVE: begin
                ram_we = 1'b1;
            end
            ST_T_DIV: begin
                ram_wdata.px = px_reg;
                ram_wdata.py = py_reg;
                ram_wdata.vx = cur_reg.vx;
                ram_wdata.vy = vy_reg;
                ram_wdata.life = life_new_reg;
                ram_wdata.rgba = {cur_reg.rgba[31:8], alpha};
                ram_we = div_done;
            end
            default: ;
        endcase
    end

    ppool_ram #(.WIDTH(PW), .DEPTH(POOL_SIZE)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    ppool_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(28'((29'(life_new_reg) << 8) - 29'(life_new_reg))),
        .divisor(lifetime_reg), .done(div_done), .quot(div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
            m_valid_reg <= 1'b0;
            anim_reg <= 1'b1;
            lifetime_reg <= 20'd65536;
            grav_reg <= 21'sd102400;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_ANIM: anim_reg <= cfg_wdata[0];
                    CFG_LIFETIME: lifetime_reg <= cfg_wdata[LIFETIME_W-1:0];
                    CFG_GRAVITY: grav_reg <= $signed(cfg_wdata[GRAV_W-1:0]);
                    default: ;
                endcase
            end
            if (m_tready && !m_load) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_x_reg <= $signed(s_tdata[23:0]);
                        in_y_reg <= $signed(s_tdata[47:24]);
                        in_rgba_reg <= s_tdata[79:48];
                        ang_reg <= s_tdata[88:80];
                        spd_reg <= 8'(s_tdata[95:89]) + 8'd50;
                        ft_reg <= s_tdata[111:96];
                        idx_reg <= '0;
                        state_reg <= s_tuser ? ST_T_LOOP : ST_SP_MUL;
                    end
                end
                ST_SP_MUL: begin
                    sinp_reg <= SIN_ROM[f_sin.q*16 +: 16] * spd_reg;
                    cosp_reg <= SIN_ROM[f_cos.q*16 +: 16] * spd_reg;
                    sin_neg_reg <= f_sin.neg;
                    cos_neg_reg <= f_cos.neg;
                    state_reg <= ST_SP_WR;
                end
                ST_SP_WR: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg <= KIND_SPAWN;
                        m_last_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                        if (!anim_reg) begin
                            m_data_reg <= {1'b0, cnt_reg, 86'd0, STAT_OFF};
                        end else if (cnt_reg >= CNT_W'(POOL_SIZE)) begin
                            m_data_reg <= {1'b0, cnt_reg, 86'd0, STAT_FULL};
                        end else begin
                            cnt_reg <= cnt_reg + 7'd1;
                            m_data_reg <= {1'b0, cnt_reg + 7'd1, in_rgba_reg, in_y_reg,
                                           in_x_reg, SLOT_W'(cnt_reg), STAT_OK};
                        end
                    end
                end
                ST_T_LOOP: begin
                    if (idx_reg < cnt_reg) begin
                        state_reg <= ST_T_EVAL;
                    end else begin
                        idx_reg <= '0;
                        state_reg <= ST_E_LOOP;
                    end
                end
                ST_T_EVAL: begin
                    if (expired) begin
                        cnt_reg <= cnt_dec;
                        state_reg <= (idx_reg < cnt_dec) ? ST_T_MOVE : ST_T_LOOP;
                    end else begin
                        cur_reg <= ram_rdata;
                        prodx_reg <= ram_rdata.vx * ft_s;
                        prody_reg <= ram_rdata.vy * ft_s;
                        prodg_reg <= grav_reg * ft_s;
                        life_new_reg <= ram_rdata.life - LIFE_W'(ft_reg);
                        state_reg <= ST_T_UPD;
                    end
                end
                ST_T_MOVE: begin
                    state_reg <= ST_T_LOOP;
                end
                ST_T_UPD: begin
                    px_reg <= sat24(27'(cur_reg.px) + 27'(round16(prodx_reg)));
                    py_reg <= sat24(27'(cur_reg.py) + 27'(round16(prody_reg)));
                    vy_reg <= sat24(27'(cur_reg.vy) + 27'(round16(prodg_reg)));
                    sat_alpha_reg <= life_new_reg >= LIFE_W'(lifetime_reg);
                    state_reg <= ST_T_DIV;
                end
                ST_T_DIV: begin
                    if (div_done) begin
                        idx_reg <= idx_reg + 7'd1;
                        state_reg <= ST_T_LOOP;
                    end
                end
                ST_E_LOOP: begin
                    if (out_free) begin
                        if (cnt_reg == '0) begin
                            m_valid_reg <= 1'b1;
                            m_kind_reg <= KIND_EMPTY;
                            m_last_reg <= 1'b1;
                            m_data_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_E_OUT;
                        end
                    end
                end
                ST_E_OUT: begin
                    m_valid_reg <= 1'b1;
                    m_kind_reg <= KIND_REPORT;
                    m_last_reg <= (idx_reg == cnt_dec);
                    m_data_reg <= {1'b0, cnt_reg, ram_rdata.rgba, ram_rdata.py,
                                   ram_rdata.px, SLOT_W'(idx_reg), STAT_OK};
                    idx_reg <= idx_reg + 7'd1;
                    state_reg <= (idx_reg == cnt_dec) ? ST_IDLE : ST_E_LOOP;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(POOL_SIZE))
    `ASSERT_IMPLY(a_empty_last, m_tvalid && m_tuser == KIND_EMPTY, m_tlast)
    `ASSERT_IMPLY(a_walk_bound, state_reg == ST_T_LOOP, idx_reg <= cnt_reg)
endmodule
